>>> sv/lhe_pkg.sv
package lhe_pkg;

  typedef logic [7:0] char_t;

  localparam int unsigned RUN_MAX = 8;
  localparam int unsigned NAME_MAX = 6;

  typedef struct packed {
    char_t [RUN_MAX-1:0] chars;
    logic [2:0]          last_idx;
  } run_t;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam char_t ASCII_MAX = 8'd127;
  localparam char_t NAME_BASE = 8'd160;
  localparam char_t CH_AMP    = 8'h26;
  localparam char_t CH_HASH   = 8'h23;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_SUB    = 8'h1A;

  // Entity name, right aligned, zero padded on the left.
  function automatic logic [8*NAME_MAX-1:0] entity_name(input logic [6:0] idx);
    logic [8*NAME_MAX-1:0] n;
    n = '0;
    case (idx)
      7'd0:  n = "nbsp";   7'd1:  n = "iexcl";  7'd2:  n = "cent";   7'd3:  n = "pound";
      7'd4:  n = "curren"; 7'd5:  n = "yen";    7'd6:  n = "brvbar"; 7'd7:  n = "sect";
      7'd8:  n = "uml";    7'd9:  n = "copy";   7'd10: n = "ordf";   7'd11: n = "laquo";
      7'd12: n = "not";    7'd13: n = "shy";    7'd14: n = "reg";    7'd15: n = "macr";
      7'd16: n = "deg";    7'd17: n = "plusmn"; 7'd18: n = "sup2";   7'd19: n = "sup3";
      7'd20: n = "acute";  7'd21: n = "micro";  7'd22: n = "para";   7'd23: n = "middot";
      7'd24: n = "cedil";  7'd25: n = "sup1";   7'd26: n = "ordm";   7'd27: n = "raquo";
      7'd28: n = "frac14"; 7'd29: n = "frac12"; 7'd30: n = "frac34"; 7'd31: n = "iquest";
      7'd32: n = "Agrave"; 7'd33: n = "Aacute"; 7'd34: n = "Acirc";  7'd35: n = "Atilde";
      7'd36: n = "Auml";   7'd37: n = "Aring";  7'd38: n = "AElig";  7'd39: n = "Ccedil";
      7'd40: n = "Egrave"; 7'd41: n = "Eacute"; 7'd42: n = "Ecirc";  7'd43: n = "Euml";
      7'd44: n = "Igrave"; 7'd45: n = "Iacute"; 7'd46: n = "Icirc";  7'd47: n = "Iuml";
      7'd48: n = "ETH";    7'd49: n = "Ntilde"; 7'd50: n = "Ograve"; 7'd51: n = "Oacute";
      7'd52: n = "Ocirc";  7'd53: n = "Otilde"; 7'd54: n = "Ouml";   7'd55: n = "times";
      7'd56: n = "Oslash"; 7'd57: n = "Ugrave"; 7'd58: n = "Uacute"; 7'd59: n = "Ucirc";
      7'd60: n = "Uuml";   7'd61: n = "Yacute"; 7'd62: n = "THORN";  7'd63: n = "szlig";
      7'd64: n = "agrave"; 7'd65: n = "aacute"; 7'd66: n = "acirc";  7'd67: n = "atilde";
      7'd68: n = "auml";   7'd69: n = "aring";  7'd70: n = "aelig";  7'd71: n = "ccedil";
      7'd72: n = "egrave"; 7'd73: n = "eacute"; 7'd74: n = "ecirc";  7'd75: n = "euml";
      7'd76: n = "igrave"; 7'd77: n = "iacute"; 7'd78: n = "icirc";  7'd79: n = "iuml";
      7'd80: n = "eth";    7'd81: n = "ntilde"; 7'd82: n = "ograve"; 7'd83: n = "oacute";
      7'd84: n = "ocirc";  7'd85: n = "otilde"; 7'd86: n = "ouml";   7'd87: n = "divide";
      7'd88: n = "oslash"; 7'd89: n = "ugrave"; 7'd90: n = "uacute"; 7'd91: n = "ucirc";
      7'd92: n = "uuml";   7'd93: n = "yacute"; 7'd94: n = "thorn";  7'd95: n = "yuml";
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> sv/lhe_front.sv
module lhe_front
  import lhe_pkg::*;
#(
  parameter int unsigned ENTITY_COUNT = 96
) (
  input  logic  op_i,
  input  char_t in_byte_i,
  output run_t  run_o
);

  logic [8*NAME_MAX-1:0] nm;
  logic [8*NAME_MAX-1:0] nm_al;
  logic [2:0]            nlen;
  logic [2:0]            semi_pos;
  char_t                 off;
  logic                  hund2;
  logic [6:0]            rem;
  logic [14:0]           prod;
  logic [3:0]            tens;
  logic [3:0]            ones;

  always_comb begin
    off      = in_byte_i - NAME_BASE;
    nm       = entity_name(off[6:0]);
    nlen     = '0;
    for (int k = 0; k < NAME_MAX; k++) begin
      if (nm[8*k +: 8] != '0) begin
        nlen = nlen + 3'd1;
      end
    end
    nm_al    = nm << (6'd8 * (6'(NAME_MAX) - 6'(nlen)));
    semi_pos = nlen + 3'd1;

    hund2 = (in_byte_i >= 8'd200);
    rem   = hund2 ? 7'(in_byte_i - 8'd200) : 7'(in_byte_i - 8'd100);
    prod  = 15'(rem) * 15'd205;
    tens  = prod[14:11];
    ones  = 4'(rem - 7'(tens) * 7'd10);

    run_o = '0;
    if (op_i == OP_EOF) begin
      run_o.chars[0] = CH_CR;
      run_o.chars[1] = CH_LF;
      run_o.chars[2] = CH_SUB;
      run_o.last_idx = 3'd2;
    end else if (in_byte_i <= ASCII_MAX) begin
      run_o.chars[0] = in_byte_i;
      run_o.last_idx = 3'd0;
    end else if (in_byte_i >= NAME_BASE && off < 8'(ENTITY_COUNT)) begin
      run_o.chars[0] = CH_AMP;
      for (int k = 0; k < NAME_MAX; k++) begin
        run_o.chars[k+1] = nm_al[8*(NAME_MAX-k)-1 -: 8];
      end
      for (int i = 1; i < RUN_MAX; i++) begin
        if (3'(i) == semi_pos) begin
          run_o.chars[i] = CH_SEMI;
        end
      end
      run_o.last_idx = semi_pos;
    end else begin
      run_o.chars[0] = CH_AMP;
      run_o.chars[1] = CH_HASH;
      run_o.chars[2] = hund2 ? CH_ZERO + 8'd2 : CH_ZERO + 8'd1;
      run_o.chars[3] = CH_ZERO + 8'(tens);
      run_o.chars[4] = CH_ZERO + 8'(ones);
      run_o.chars[5] = CH_SEMI;
      run_o.last_idx = 3'd5;
    end
  end

endmodule

>>> sv/lhe_queue.sv
module lhe_queue
  import lhe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output run_t head_o
);

  run_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2 || pop_i))
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("queue read while empty");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

>>> sv/lhe_back.sv
module lhe_back
  import lhe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  run_t  head_i,
  output logic  q_pop_o,
  output logic  empty_o,
  input  logic  pop_i,
  output char_t out_char_o,
  output logic  run_last_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  char_t      out_char_q;
  logic       run_last_q;
  logic       emit;
  logic       is_last;

  assign emit    = !q_empty_i && (!out_valid_q || pop_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign q_pop_o = emit && is_last;

  assign empty_o    = !out_valid_q;
  assign out_char_o = out_char_q;
  assign run_last_o = run_last_q;

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
    out_valid_d = emit || (out_valid_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= head_i.chars[idx_q];
      run_last_q <= is_last;
    end
  end

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> (idx_q <= head_i.last_idx))
    else $error("character index past end of run");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && out_valid_q && !pop_i) |=> (idx_q == $past(idx_q)))
    else $error("run advanced while output stalled");

endmodule

>>> sv/latin1_html_entity_encoder_top.sv
// Channel  Handshake             Ports
// input    push / full           op_i, in_byte_i
// output   empty / pop           out_char_o, run_last_o
//
// One character leaves per cycle while pop is held; an item yields 1 to 8 characters, so plain
// ASCII sustains one item per cycle and expanded bytes hold the input by
// backpressure through the two-entry run queue.
// The first character of an item reaches the ports through the run queue and then the output register.
// Reset empties the queue and the output register and rewinds the character index; nothing else holds state.
// The input stalls only when the run queue is full; the output register
// refills in the cycle it is popped, provided the run queue is not empty.
module latin1_html_entity_encoder_top
  import lhe_pkg::*;
#(
  parameter int unsigned ENTITY_COUNT = 96
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  logic  op_i,
  input  char_t in_byte_i,
  output logic  empty,
  input  logic  pop,
  output char_t out_char_o,
  output logic  run_last_o
);

  run_t run;
  run_t head;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign full = q_full;

  lhe_front #(
    .ENTITY_COUNT(ENTITY_COUNT)
  ) u_front (
    .op_i      (op_i),
    .in_byte_i (in_byte_i),
    .run_o     (run)
  );

  lhe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !q_full),
    .data_i  (run),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  lhe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o)
  );

endmodule

>>> test/tb.sv
module tb
  import lhe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ENTITIES = 96;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLDOFF_LEN  = 300;

  typedef struct {
    char_t ch;
    logic  last;
  } encoded_char_t;

  string entity_names [0:95] = '{
    "nbsp",   "iexcl",  "cent",   "pound",  "curren", "yen",    "brvbar", "sect",
    "uml",    "copy",   "ordf",   "laquo",  "not",    "shy",    "reg",    "macr",
    "deg",    "plusmn", "sup2",   "sup3",   "acute",  "micro",  "para",   "middot",
    "cedil",  "sup1",   "ordm",   "raquo",  "frac14", "frac12", "frac34", "iquest",
    "Agrave", "Aacute", "Acirc",  "Atilde", "Auml",   "Aring",  "AElig",  "Ccedil",
    "Egrave", "Eacute", "Ecirc",  "Euml",   "Igrave", "Iacute", "Icirc",  "Iuml",
    "ETH",    "Ntilde", "Ograve", "Oacute", "Ocirc",  "Otilde", "Ouml",   "times",
    "Oslash", "Ugrave", "Uacute", "Ucirc",  "Uuml",   "Yacute", "THORN",  "szlig",
    "agrave", "aacute", "acirc",  "atilde", "auml",   "aring",  "aelig",  "ccedil",
    "egrave", "eacute", "ecirc",  "euml",   "igrave", "iacute", "icirc",  "iuml",
    "eth",    "ntilde", "ograve", "oacute", "ocirc",  "otilde", "ouml",   "divide",
    "oslash", "ugrave", "uacute", "ucirc",  "uuml",   "yacute", "thorn",  "yuml"
  };

  logic  clk_i     = 1'b0;
  logic  rst_ni    = 1'b0;
  logic  push      = 1'b0;
  logic  op_i      = OP_DATA;
  char_t in_byte_i = '0;
  logic  pop       = 1'b0;
  logic  full;
  logic  empty;
  char_t out_char_o;
  logic  run_last_o;

  encoded_char_t pending_chars[$];
  int unsigned   error_count   = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   pop_stall_pct = 0;
  int unsigned   holdoff_left  = 0;
  int unsigned   quiet_cycles  = 0;

  latin1_html_entity_encoder_top #(
    .ENTITY_COUNT(NUM_ENTITIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .op_i       (op_i),
    .in_byte_i  (in_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void queue_encoding(input logic op, input char_t b);
    char_t       run [8];
    int unsigned len;
    int unsigned idx;
    string       nm;
    len = 0;
    if (op == OP_EOF) begin
      run[0] = CH_CR;
      run[1] = CH_LF;
      run[2] = CH_SUB;
      len = 3;
    end else if (b <= ASCII_MAX) begin
      run[0] = b;
      len = 1;
    end else if (b >= NAME_BASE && int'(b - NAME_BASE) < NUM_ENTITIES) begin
      idx = b - NAME_BASE;
      nm = entity_names[idx];
      run[len++] = CH_AMP;
      for (int k = 0; k < nm.len(); k++) run[len++] = char_t'(nm[k]);
      run[len++] = CH_SEMI;
    end else begin
      run[0] = CH_AMP;
      run[1] = CH_HASH;
      run[2] = CH_ZERO + char_t'((b / 100) % 10);
      run[3] = CH_ZERO + char_t'((b / 10) % 10);
      run[4] = CH_ZERO + char_t'(b % 10);
      run[5] = CH_SEMI;
      len = 6;
    end
    for (int k = 0; k < len; k++) begin
      pending_chars.push_back('{ch: run[k], last: (k == len - 1)});
    end
  endfunction

  // Leaves push high on return; stop_sending lowers it.
  task automatic send_item(input logic op, input char_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    push      <= 1'b1;
    op_i      <= op;
    in_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    queue_encoding(op, b);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      send_item(OP_DATA, char_t'($urandom_range(127, 0)));
    else if (pick < 70) send_item(OP_DATA, char_t'($urandom_range(255, 160)));
    else if (pick < 85) send_item(OP_DATA, char_t'($urandom_range(159, 128)));
    else if (pick < 95) send_item(OP_EOF, char_t'($urandom_range(255, 0)));
    else                send_item(logic'($urandom_range(1, 0)), char_t'($urandom()));
  endtask

  task automatic test_ascii_passthrough();
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'h7F);
    send_item(OP_DATA, 8'h55);
    send_item(OP_DATA, 8'h2A);
    send_item(OP_DATA, 8'h41);
    stop_sending();
  endtask

  task automatic test_named_entities();
    send_item(OP_DATA, 8'd160);
    send_item(OP_DATA, 8'd164);
    send_item(OP_DATA, 8'd168);
    send_item(OP_DATA, 8'd208);
    send_item(OP_DATA, 8'd215);
    send_item(OP_DATA, 8'd255);
    stop_sending();
  endtask

  task automatic test_numeric_form();
    send_item(OP_DATA, 8'd128);
    send_item(OP_DATA, 8'd141);
    send_item(OP_DATA, 8'd159);
    stop_sending();
  endtask

  task automatic test_end_of_file();
    send_item(OP_EOF, 8'h00);
    send_item(OP_EOF, 8'hFF);
    send_item(OP_DATA, 8'hAA);
    stop_sending();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (count) send_random_item();
    stop_sending();
  endtask

  // Output held off long enough that the run queue fills and full stalls the sender.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    holdoff_left  = HOLDOFF_LEN;
    repeat (30) send_random_item();
    stop_sending();
  endtask

  always @(posedge clk_i) begin : check_output
    encoded_char_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected item: out_char %h run_last %b", out_char_o, run_last_o);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char_o);
          error_count++;
        end
        if (run_last_o !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, run_last_o);
          error_count++;
        end
      end
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (holdoff_left > 0) begin
      pop <= 1'b0;
      holdoff_left--;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii_passthrough();
    test_named_entities();
    test_numeric_form();
    test_end_of_file();
    test_random_traffic(110, 0, 0);
    test_random_traffic(110, 58, 0);
    test_random_traffic(110, 0, 58);
    test_random_traffic(90, 23, 23);
    test_output_holdoff();
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
